FILE: src/qesm_pkg.sv
`default_nettype none
package qesm_pkg;

	// channel field is 2 bits and the invert mask 4 bits wide
	localparam int NUM_CHANNELS = 4;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_SPEED  = 1'b1;

	localparam logic REG_INVERT_MASK = 1'b0;
	localparam logic REG_COUNTS_PER_REV = 1'b1;

	localparam logic [3:0]  INVERT_MASK_RESET    = 4'd6;
	localparam logic [15:0] COUNTS_PER_REV_RESET = 16'd3200;

	// 60000 ms/min * 16 (q4 fraction)
	localparam int          SCALE_W   = 20;
	localparam logic [19:0] RPM_SCALE = 20'd960000;
	localparam int          DEN_W     = 32;

	localparam logic [31:0] SPEED_MAX = 32'h7fff_ffff;
	localparam logic [31:0] SPEED_MIN = 32'h8000_0000;

	typedef struct packed {
		logic        op;
		logic [1:0]  channel;
		logic        a_level;
		logic        b_level;
		logic [15:0] elapsed_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         speed_channel;
		logic signed [31:0] speed_rpm_q4;
		logic               last_of_run;
	} out_item_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'b00,
		DIR_UP   = 2'b01,
		DIR_DOWN = 2'b10
	} dir_t;

	typedef struct packed {
		logic sample;
		logic start;
		logic load;
		logic mul;
		logic div_step;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_last;
		logic last_ch;
		logic out_free;
	} ctrl_sts_t;

	// Gray-code step decode: old state -> new state
	function automatic dir_t step_dir(input logic [1:0] old_ab, input logic [1:0] new_ab);
		dir_t d;
		unique case ({old_ab, new_ab})
			4'b0001, 4'b0111, 4'b1110, 4'b1000: d = DIR_UP;
			4'b0010, 4'b1011, 4'b1101, 4'b0100: d = DIR_DOWN;
			default:                            d = DIR_NONE;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

FILE: src/qesm_ctrl.sv
`default_nettype none
module qesm_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_op,
	output logic                       in_ready,
	input  wire qesm_pkg::ctrl_sts_t   sts,
	output qesm_pkg::ctrl_cmd_t        cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_LOAD  = 5'b00010,
		S_MUL   = 5'b00100,
		S_DIV   = 5'b01000,
		S_WRITE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		cmd.sample   = accept && (in_op == qesm_pkg::OP_SAMPLE);
		cmd.start    = accept && (in_op == qesm_pkg::OP_SPEED);
		cmd.load     = (state_q == S_LOAD);
		cmd.mul      = (state_q == S_MUL);
		cmd.div_step = (state_q == S_DIV);
		cmd.emit     = (state_q == S_WRITE) && sts.out_free;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.start) state_d = S_LOAD;
			end
			S_LOAD:  state_d = S_MUL;
			S_MUL:   state_d = S_DIV;
			S_DIV: begin
				if (sts.div_last) state_d = S_WRITE;
			end
			S_WRITE: begin
				if (sts.out_free) state_d = sts.last_ch ? S_IDLE : S_LOAD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

FILE: src/qesm_dp.sv
`default_nettype none
module qesm_dp #(
	parameter int COUNT_WIDTH  = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire qesm_pkg::in_item_t   in_item,
	input  wire logic [3:0]           invert_mask,
	input  wire logic [15:0]          counts_per_rev,
	input  wire qesm_pkg::ctrl_cmd_t  cmd,
	output qesm_pkg::ctrl_sts_t       sts,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output qesm_pkg::out_item_t       out_item
);

	localparam int NUM_CHANNELS = qesm_pkg::NUM_CHANNELS;
	localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int NUM_W = COUNT_WIDTH + qesm_pkg::SCALE_W;
	localparam int BIT_W = $clog2(NUM_W + 1);
	localparam int DEN_W = qesm_pkg::DEN_W;
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	logic signed [COUNT_WIDTH-1:0] count_q [NUM_CHANNELS];
	logic [1:0]                    prev_q  [NUM_CHANNELS];

	logic [CH_W-1:0]        idx_q;
	logic [15:0]            elapsed_q;
	logic [COUNT_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic                   zero_q;
	logic [DEN_W-1:0]       den_q;
	logic [NUM_W-1:0]       num_q;
	logic [DEN_W-1:0]       rem_q;
	logic [BIT_W-1:0]       bit_q;
	logic                   out_valid_q;
	qesm_pkg::out_item_t    out_q;

	logic [CH_W-1:0]               rd_idx;
	logic                          in_range;
	logic signed [COUNT_WIDTH-1:0] cnt_rd;
	logic signed [COUNT_WIDTH-1:0] cnt_new;
	logic [1:0]                    ab;
	qesm_pkg::dir_t                dir;
	logic                          inv;
	logic [DEN_W:0]                trial;
	logic                          qbit;
	logic [63:0]                   q64;
	logic [31:0]                   q_pos;
	logic [31:0]                   q_neg;
	logic [31:0]                   speed;

	assign in_range = ({3'b000, in_item.channel} < 5'(NUM_CHANNELS));
	assign rd_idx   = cmd.sample ? CH_W'(in_item.channel) : idx_q;
	assign cnt_rd   = count_q[rd_idx];
	assign ab       = {in_item.a_level, in_item.b_level};
	assign inv      = invert_mask[in_item.channel];

	always_comb begin
		dir     = qesm_pkg::step_dir(prev_q[rd_idx], ab);
		cnt_new = cnt_rd;
		if (inv) begin
			unique case (dir)
				qesm_pkg::DIR_UP:   dir = qesm_pkg::DIR_DOWN;
				qesm_pkg::DIR_DOWN: dir = qesm_pkg::DIR_UP;
				default:            dir = qesm_pkg::DIR_NONE;
			endcase
		end
		if (dir == qesm_pkg::DIR_UP && cnt_rd != CNT_MAX) cnt_new = cnt_rd + 1'b1;
		else if (dir == qesm_pkg::DIR_DOWN && cnt_rd != CNT_MIN) cnt_new = cnt_rd - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				count_q[i] <= '0;
				prev_q[i]  <= '0;
			end
		end else if (cmd.sample && in_range) begin
			count_q[rd_idx] <= cnt_new;
			prev_q[rd_idx]  <= ab;
		end else if (cmd.load) begin
			count_q[rd_idx] <= '0;
		end
	end

	// restoring divider, quotient shifts into num_q
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.start) elapsed_q <= in_item.elapsed_ms;
		if (cmd.load) begin
			neg_q  <= cnt_rd[COUNT_WIDTH-1];
			zero_q <= (cnt_rd == '0);
			mag_q  <= cnt_rd[COUNT_WIDTH-1] ? (COUNT_WIDTH'(0) - cnt_rd) : cnt_rd;
			den_q  <= DEN_W'(elapsed_q) * DEN_W'(counts_per_rev);
		end
		if (cmd.mul) begin
			num_q <= NUM_W'(mag_q) * NUM_W'(qesm_pkg::RPM_SCALE);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NUM_W-2:0], qbit};
			rem_q <= qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			bit_q <= '0;
		end else begin
			if (cmd.start) idx_q <= '0;
			else if (cmd.emit && !sts.last_ch) idx_q <= idx_q + 1'b1;
			if (cmd.mul) bit_q <= BIT_W'(NUM_W);
			else if (cmd.div_step) bit_q <= bit_q - 1'b1;
		end
	end

	assign q64   = 64'(num_q);
	assign q_pos = (q64 > 64'(qesm_pkg::SPEED_MAX)) ? qesm_pkg::SPEED_MAX : q64[31:0];
	assign q_neg = (q64 > 64'(qesm_pkg::SPEED_MIN)) ? qesm_pkg::SPEED_MIN : q64[31:0];

	always_comb begin
		if (zero_q) speed = '0;
		else if (den_q == '0) speed = neg_q ? qesm_pkg::SPEED_MIN : qesm_pkg::SPEED_MAX;
		else speed = neg_q ? (32'd0 - q_neg) : q_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.speed_channel <= 2'(idx_q);
			out_q.speed_rpm_q4  <= speed;
			out_q.last_of_run   <= sts.last_ch;
		end
	end

	assign sts.div_last = (bit_q == BIT_W'(1));
	assign sts.last_ch  = (idx_q == CH_W'(NUM_CHANNELS - 1));
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire

FILE: src/quad_encoder_speed_meter_unit.sv
// Pin sample: one per cycle while idle, no result; count updated at the accepting edge.
// Speed request: per channel load, multiply, one quotient bit per cycle in the shared
// restoring divider, then output; NUM_CHANNELS results in all; input stalls meanwhile.
// The last result waits in the output register while new transactions are taken.
// Reset (async, active low): counts and previous states zero, registers to defaults.
`default_nettype none
module quad_encoder_speed_meter_unit #(
	parameter int COUNT_WIDTH  = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire qesm_pkg::in_item_t   in_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output qesm_pkg::out_item_t       out_item,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	logic [3:0]          mask_q;
	logic [15:0]         cpr_q;
	logic                reg_wr;
	qesm_pkg::ctrl_cmd_t cmd;
	qesm_pkg::ctrl_sts_t sts;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= qesm_pkg::INVERT_MASK_RESET;
			cpr_q  <= qesm_pkg::COUNTS_PER_REV_RESET;
		end else if (reg_wr) begin
			if (paddr[2] == qesm_pkg::REG_INVERT_MASK) mask_q <= pwdata[3:0];
			else cpr_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == qesm_pkg::REG_COUNTS_PER_REV) ? {16'd0, cpr_q} : {28'd0, mask_q};

	qesm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_item.op),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	qesm_dp #(
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_item        (in_item),
		.invert_mask    (mask_q),
		.counts_per_rev (cpr_q),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_item       (out_item)
	);

	a_speed_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.op == qesm_pkg::OP_SPEED |=> !in_ready)
		else $error("input taken right after speed request");

	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.last_of_run |->
		out_item.speed_channel == 2'(qesm_pkg::NUM_CHANNELS - 1))
		else $error("last result not on last channel");

	a_mid_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.last_of_run |-> !in_ready)
		else $error("input ready in the middle of a speed run");

	a_emit_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_valid || out_ready)
		else $error("result overwritten before transaction");

endmodule
`default_nettype wire

FILE: test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH = 4;
	localparam int CNT_W = 24;
	localparam int CNT_HI = (1 << (CNT_W - 1)) - 1;
	localparam int CNT_LO = -(1 << (CNT_W - 1));
	localparam longint unsigned Q4_PER_RPM_MS = 960000;	// 60000 ms/min, 16 steps per rpm
	localparam logic signed [31:0] RPM_HI = 32'sh7fff_ffff;
	localparam logic signed [31:0] RPM_LO = 32'sh8000_0000;
	localparam logic [NCH-1:0][31:0] NO_RPM = '0;
	localparam int SETTLE = NCH * (CNT_W + 23) + 16;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		qesm_pkg::in_item_t it;
		bit typed;
		logic [NCH-1:0][31:0] want_rpm;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	qesm_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	qesm_pkg::out_item_t out_item;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// predictor state
	logic [1:0] last_ab [NCH];
	int pulses [NCH];
	logic [3:0] inv_mask;
	logic [15:0] rev_counts;
	qesm_pkg::out_item_t run_res [NCH];

	qesm_pkg::out_item_t speed_due [$];
	qesm_pkg::out_item_t want;
	plan_row_t plan [$];
	int errors = 0;
	int rx_gap = 0;
	int in_gap = 0;
	int cycles = 0;
	bit no_idle = 1'b0;

	always #2 clk = ~clk;

	quad_encoder_speed_meter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// {old, new} -> +1 forward step, -1 reverse step, 0 otherwise
	function automatic int gray_dir(input logic [3:0] old_new);
		case (old_new)
			4'b0001, 4'b0111, 4'b1110, 4'b1000: return 1;
			4'b0010, 4'b1011, 4'b1101, 4'b0100: return -1;
			default: return 0;
		endcase
	endfunction

	function automatic logic [1:0] gray_next(input logic [1:0] cur, input bit up);
		logic [1:0] cand;
		cand = cur;
		for (int k = 0; k < 4; k++)
			if (gray_dir({cur, 2'(k)}) == (up ? 1 : -1))
				cand = 2'(k);
		return cand;
	endfunction

	function automatic logic signed [31:0] rpm_q4(input int cnt, input logic [15:0] ms);
		longint unsigned den, mag, q;
		logic [31:0] q32;
		den = longint'(ms) * longint'(rev_counts);
		mag = (cnt < 0) ? longint'(-cnt) : longint'(cnt);
		if (cnt == 0)
			return 32'sd0;
		if (den == 0)
			return (cnt < 0) ? RPM_LO : RPM_HI;
		q = mag * Q4_PER_RPM_MS / den;
		if (cnt < 0) begin
			if (q > 64'h8000_0000)
				return RPM_LO;
			q32 = q[31:0];
			return -q32;
		end
		if (q > 64'h7fff_ffff)
			return RPM_HI;
		return q[31:0];
	endfunction

	function automatic int meter_step(input qesm_pkg::in_item_t it);
		int d;
		if (it.op == qesm_pkg::OP_SAMPLE) begin
			d = gray_dir({last_ab[it.channel], it.a_level, it.b_level});
			if (inv_mask[it.channel])
				d = -d;
			last_ab[it.channel] = {it.a_level, it.b_level};
			if (d > 0 && pulses[it.channel] < CNT_HI)
				pulses[it.channel]++;
			else if (d < 0 && pulses[it.channel] > CNT_LO)
				pulses[it.channel]--;
			return 0;
		end
		for (int c = 0; c < NCH; c++) begin
			run_res[c].speed_channel = 2'(c);
			run_res[c].speed_rpm_q4 = rpm_q4(pulses[c], it.elapsed_ms);
			run_res[c].last_of_run = (c == NCH - 1);
			pulses[c] = 0;
		end
		return NCH;
	endfunction

	function automatic qesm_pkg::in_item_t pin(input logic [1:0] ch, input logic [1:0] ab);
		qesm_pkg::in_item_t it;
		it.op = qesm_pkg::OP_SAMPLE;
		it.channel = ch;
		{it.a_level, it.b_level} = ab;
		it.elapsed_ms = 16'($urandom);
		return it;
	endfunction

	function automatic qesm_pkg::in_item_t speed_req(input logic [15:0] ms);
		qesm_pkg::in_item_t it;
		it.op = qesm_pkg::OP_SPEED;
		it.channel = 2'($urandom);
		it.a_level = 1'($urandom);
		it.b_level = 1'($urandom);
		it.elapsed_ms = ms;
		return it;
	endfunction

	function automatic void flag(input string what, input qesm_pkg::out_item_t got,
			input qesm_pkg::out_item_t due);
		if (errors < 10)
			$display("%s: got ch %0d rpm_q4 %0d last %0b, want ch %0d rpm_q4 %0d last %0b",
				what, got.speed_channel, got.speed_rpm_q4, got.last_of_run,
				due.speed_channel, due.speed_rpm_q4, due.last_of_run);
		errors++;
	endfunction

	function automatic void reg_check(input logic [31:0] got, input logic [31:0] due);
		if (got !== due) begin
			if (errors < 10)
				$display("register readback: got %0h, want %0h", got, due);
			errors++;
		end
	endfunction

	task automatic send_txn(input qesm_pkg::in_item_t it);
		repeat (in_gap) @(posedge clk);
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		in_gap = no_idle ? 0 : $urandom_range(0, 16);
		if (in_gap != 0)
			in_valid <= 1'b0;
	endtask

	task automatic drive(input qesm_pkg::in_item_t it, input bit typed,
			input logic [NCH-1:0][31:0] want_rpm);
		int n;
		send_txn(it);
		n = meter_step(it);
		for (int c = 0; c < n; c++) begin
			if (typed)
				run_res[c].speed_rpm_q4 = want_rpm[c];
			speed_due.push_back(run_res[c]);
		end
	endtask

	// hold off the sender until every speed result is back and the block is quiet
	task automatic settle();
		if (in_gap == 0)
			in_valid <= 1'b0;
		in_gap = 0;
		while (speed_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_config(input logic [3:0] mask, input logic [15:0] per_rev);
		reg_write(qesm_pkg::REG_INVERT_MASK, {28'd0, mask});
		reg_write(qesm_pkg::REG_COUNTS_PER_REV, {16'd0, per_rev});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		inv_mask = mask;
		rev_counts = per_rev;
		@(posedge clk);
		reg_check(prdata, {16'd0, per_rev});
		paddr <= {qesm_pkg::REG_INVERT_MASK, 2'b00};
		@(posedge clk);
		reg_check(prdata, {28'd0, mask});
	endtask

	task automatic random_run(input int n);
		int done, pick, len;
		logic [1:0] ch;
		bit up;
		logic [15:0] ms;
		done = 0;
		while (done < n) begin
			if ($urandom_range(0, 39) == 0)
				no_idle = !no_idle;
			pick = $urandom_range(0, 99);
			if (pick < 18) begin
				case ($urandom_range(0, 9))
					0: ms = 16'hffff;
					1: ms = 16'($urandom);
					2: ms = 16'($urandom_range(0, 3));
					default: ms = 16'($urandom_range(1, 200));
				endcase
				drive(speed_req(ms), 1'b0, NO_RPM);
				done++;
				if ($urandom_range(0, 7) == 0)
					settle();
			end else if (pick < 88) begin
				// clean run of gray steps in one direction
				ch = 2'($urandom);
				up = 1'($urandom);
				len = $urandom_range(1, 12);
				repeat (len) begin
					drive(pin(ch, gray_next(last_ab[ch], up)), 1'b0, NO_RPM);
					done++;
				end
			end else begin
				drive(pin(2'($urandom), 2'($urandom)), 1'b0, NO_RPM);
				done++;
			end
		end
		no_idle = 1'b0;
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (speed_due.size() == 0) begin
				flag("unexpected result", out_item, '0);
			end else begin
				want = speed_due.pop_front();
				if (out_item.speed_channel !== want.speed_channel ||
						out_item.speed_rpm_q4 !== want.speed_rpm_q4 ||
						out_item.last_of_run !== want.last_of_run)
					flag("mismatch", out_item, want);
			end
			rx_gap = no_idle ? 0 : $urandom_range(0, 16);
		end
		if (rx_gap != 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int k;
		for (int c = 0; c < NCH; c++) begin
			last_ab[c] = 2'b00;
			pulses[c] = 0;
		end
		inv_mask = 4'd6;
		rev_counts = 16'd3200;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan.push_back({speed_req(16'd1000), 1'b1, NO_RPM});	// nothing counted yet
		plan.push_back({pin(2'd0, 2'b01), 1'b0, NO_RPM});
		plan.push_back({pin(2'd1, 2'b01), 1'b0, NO_RPM});
		plan.push_back({pin(2'd2, 2'b10), 1'b0, NO_RPM});
		plan.push_back({pin(2'd3, 2'b11), 1'b0, NO_RPM});	// both bits flip
		plan.push_back({pin(2'd0, 2'b11), 1'b0, NO_RPM});
		plan.push_back({pin(2'd0, 2'b10), 1'b0, NO_RPM});
		plan.push_back({pin(2'd0, 2'b00), 1'b0, NO_RPM});
		plan.push_back({pin(2'd1, 2'b01), 1'b0, NO_RPM});	// no change
		plan.push_back({speed_req(16'd0), 1'b1, {32'd0, RPM_HI, RPM_LO, RPM_HI}});
		plan.push_back({pin(2'd3, 2'b01), 1'b0, NO_RPM});
		plan.push_back({pin(2'd3, 2'b00), 1'b0, NO_RPM});
		plan.push_back({pin(2'd0, 2'b10), 1'b0, NO_RPM});
		plan.push_back({pin(2'd1, 2'b10), 1'b0, NO_RPM});
		plan.push_back({speed_req(16'hffff), 1'b1, NO_RPM});	// truncates to zero
		plan.push_back({pin(2'd0, 2'b11), 1'b0, NO_RPM});
		plan.push_back({pin(2'd0, 2'b01), 1'b0, NO_RPM});
		plan.push_back({pin(2'd0, 2'b00), 1'b0, NO_RPM});
		plan.push_back({pin(2'd2, 2'b11), 1'b0, NO_RPM});
		plan.push_back({speed_req(16'd1), 1'b0, NO_RPM});
		foreach (plan[i])
			drive(plan[i].it, plan[i].typed, plan[i].want_rpm);

		// long runs in both directions, back to back
		settle();
		set_config(4'hf, 16'd1);
		no_idle = 1'b1;
		for (k = 0; k < 40; k++) begin
			drive(pin(2'd0, gray_next(last_ab[0], 1'b1)), 1'b0, NO_RPM);
			drive(pin(2'd1, gray_next(last_ab[1], 1'b0)), 1'b0, NO_RPM);
		end
		no_idle = 1'b0;
		drive(speed_req(16'd1), 1'b0, NO_RPM);
		random_run(40);

		settle();
		set_config(4'h0, 16'hffff);
		random_run(80);

		settle();
		set_config(4'($urandom), 16'd0);
		random_run(40);

		settle();
		set_config(4'($urandom), 16'($urandom_range(1, 65535)));
		random_run(70);

		settle();
		set_config(4'($urandom), 16'($urandom_range(1, 400)));
		random_run(70);

		settle();
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
